[src/dlmc_pkg.sv]
// Shared constants and codes for the debounced LED mode controller.
package dlmc_pkg;

  // Default sizing
  localparam int LED_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd200;

  // Input beat
  localparam int IN_DATA_W = 8;
  localparam int SW_W      = 2;
  localparam int NUM_SW    = 4;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  localparam logic [SW_W-1:0] SW_BLINK  = 2'd0;
  localparam logic [SW_W-1:0] SW_CHASE  = 2'd1;
  localparam logic [SW_W-1:0] SW_MANUAL = 2'd2;
  localparam logic [SW_W-1:0] SW_CLEAR  = 2'd3;

  // Modes
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // LED toggled by the manual switch
  localparam int LED_MANUAL = 2;

  // Result beat: led_bits, mode, press_accepted, timer_fired
  localparam int OUT_FLAG_W = MODE_W + 2;

endpackage

[src/debounced_led_mode_controller_core.sv]
// Debounced LED mode controller: tick/press stream in, LED status stream out.
//
// Input channel (in_*): one beat per event. in_tuser is the command
// (0 = time-base tick, 1 = switch press), in_tdata[1:0] the switch number.
// Output channel (out_*): exactly one beat per input beat, in order, carrying
// the LED bits, the mode, and flags for an accepted press and a timer expiry.
// Configuration (cfg_*): index 0 is the debounce window in ticks, index 1 the
// pattern period in ticks; write only while no beat is in flight.
//
// A beat taken into the input register is worked on from there, and its
// result is registered in the result register, which drives out_tvalid.
// Throughput is one beat per cycle while out_tready is high; the input
// register and the result register form a two-entry pipeline, so the input
// still takes a beat while a finished result waits for out_tready. With both
// stages full and out_tready low, in_tready drops and everything holds.
// Reset clears the tick counter, all press times, the LEDs and the timer,
// selects no mode, restores both configuration registers to 20 and 200 ticks
// and empties the pipeline.
module debounced_led_mode_controller_core #(
  parameter int LED_COUNT = dlmc_pkg::LED_COUNT_DEF,
  parameter int TIME_BITS = dlmc_pkg::TIME_BITS_DEF,
  parameter int OUT_W     = ((LED_COUNT + dlmc_pkg::OUT_FLAG_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [1:0] switch number, rest zero
  input  logic [dlmc_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [0] command
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: led_bits, mode, press_accepted, timer_fired, zero fill
  output logic [OUT_W-1:0]                out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [dlmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dlmc_pkg::CFG_W-1:0]      cfg_data
);
  import dlmc_pkg::*;

  localparam int IDX_W = $clog2(LED_COUNT);

  // Input stage
  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic [SW_W-1:0]      s1_sw_r;

  // Controller state
  logic [TIME_BITS-1:0] tick_r;
  logic [TIME_BITS-1:0] tick_nxt;
  logic [TIME_BITS-1:0] last_r [NUM_SW];
  logic                 last_we;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic                 rev_r, rev_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [LED_COUNT-1:0] led_r, led_nxt;
  logic                 armed_r, armed_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]     deb_r;
  logic [CFG_W-1:0]     per_r;

  // Result stage
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  logic                 can_adv;
  logic                 step;
  logic [TIME_BITS-1:0] diff;
  logic                 accepted;
  logic                 fired;
  logic [CFG_W-1:0]     reload;
  logic [CFG_W-1:0]     rem_dec;
  logic [IDX_W-1:0]     idx_step;

  assign can_adv   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && can_adv;
  assign in_tready = !s1_valid_r || can_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign reload  = (per_r == '0) ? CFG_W'(1) : per_r;
  assign rem_dec = (rem_r != '0) ? rem_r - CFG_W'(1) : '0;
  assign diff    = tick_r - last_r[s1_sw_r];

  // Next chase position
  always_comb begin
    if (!rev_r) begin
      idx_step = (idx_r == IDX_W'(LED_COUNT - 1)) ? '0 : idx_r + IDX_W'(1);
    end else begin
      idx_step = (idx_r == '0) ? IDX_W'(LED_COUNT - 1) : idx_r - IDX_W'(1);
    end
  end

  always_comb begin
    tick_nxt  = tick_r;
    mode_nxt  = mode_r;
    rev_nxt   = rev_r;
    idx_nxt   = idx_r;
    led_nxt   = led_r;
    armed_nxt = armed_r;
    rem_nxt   = rem_r;
    accepted  = 1'b0;
    fired     = 1'b0;
    last_we   = 1'b0;

    if (s1_cmd_r == CMD_TICK) begin
      tick_nxt = tick_r + TIME_BITS'(1);
      if (armed_r) begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          fired = 1'b1;
          case (mode_r)
            MODE_BLINK: begin
              led_nxt   = led_r[0] ? '0 : '1;
              armed_nxt = 1'b1;
              rem_nxt   = reload;
            end
            MODE_CHASE: begin
              led_nxt   = (led_r & ~(LED_COUNT'(1) << idx_r)) |
                          (LED_COUNT'(1) << idx_step);
              idx_nxt   = idx_step;
              armed_nxt = 1'b1;
              rem_nxt   = reload;
            end
            MODE_MANUAL: begin
              led_nxt   = ~led_r;
              armed_nxt = 1'b1;
              rem_nxt   = reload;
            end
            default: begin
              armed_nxt = 1'b0;
              rem_nxt   = '0;
            end
          endcase
        end
      end
    end else if (diff >= TIME_BITS'(deb_r)) begin
      accepted = 1'b1;
      last_we  = 1'b1;
      case (s1_sw_r)
        SW_BLINK: begin
          mode_nxt  = MODE_BLINK;
          armed_nxt = 1'b1;
          rem_nxt   = reload;
        end
        SW_CHASE: begin
          mode_nxt  = MODE_CHASE;
          rev_nxt   = !rev_r;
          // reverse runs start at LED 0, forward runs wrap in from the top
          idx_nxt   = rev_r ? IDX_W'(LED_COUNT - 1) : '0;
          armed_nxt = 1'b1;
          rem_nxt   = reload;
        end
        SW_MANUAL: begin
          mode_nxt = MODE_MANUAL;
          led_nxt  = led_r ^ (LED_COUNT'(1) << LED_MANUAL);
        end
        default: begin
          led_nxt   = '0;
          armed_nxt = 1'b0;
          rem_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_sw_r  <= in_tdata[SW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      mode_r  <= MODE_NONE;
      rev_r   <= 1'b0;
      idx_r   <= '0;
      led_r   <= '0;
      armed_r <= 1'b0;
      rem_r   <= '0;
      for (int i = 0; i < NUM_SW; i++) begin
        last_r[i] <= '0;
      end
    end else if (step) begin
      tick_r  <= tick_nxt;
      mode_r  <= mode_nxt;
      rev_r   <= rev_nxt;
      idx_r   <= idx_nxt;
      led_r   <= led_nxt;
      armed_r <= armed_nxt;
      rem_r   <= rem_nxt;
      if (last_we) begin
        last_r[s1_sw_r] <= tick_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEBOUNCE_RST;
      per_r <= PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DEBOUNCE: deb_r <= cfg_data;
        REG_PERIOD:   per_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OUT_W'({fired, accepted, mode_nxt, led_nxt});
    end
  end

endmodule

[src/dlmc_checker.sv]
// Port-level checks for the debounced LED mode controller, bound to the core.
module dlmc_checker #(
  parameter int LED_COUNT = dlmc_pkg::LED_COUNT_DEF,
  parameter int OUT_W     = 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tvalid,
  input logic             out_tready
);
  import dlmc_pkg::*;

  localparam int ACC_BIT  = LED_COUNT + MODE_W;
  localparam int FIRE_BIT = LED_COUNT + MODE_W + 1;

  // A tick never accepts a press and a press never fires the timer
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[ACC_BIT] && out_tdata[FIRE_BIT]))
    else $error("press_accepted and timer_fired both set");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present right after reset");

  // An empty result stage always leaves room at the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

endmodule

bind debounced_led_mode_controller_core dlmc_checker #(
  .LED_COUNT(LED_COUNT),
  .OUT_W    (OUT_W)
) u_dlmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
